@@ rtl/core/mbe_pkg.sv @@
package mbe_pkg;

    // Fixed-point format of c and z.
    localparam int FRACTION_BITS = 28;
    localparam int C_W           = 32;
    localparam int Z_W           = 36;
    localparam int LIMIT_W       = 10;

    // Multiplier operands: |z part| <= 2 once the range check has passed.
    localparam int OP_W   = FRACTION_BITS + 3;
    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(110);
    localparam logic [Z_W-1:0]     TWO_Z       = Z_W'(2) << FRACTION_BITS;
    localparam logic [SUM_W-1:0]   FOUR_SQ     = SUM_W'(4) << (2 * FRACTION_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DONE
    } state_t;

    // Sequencer commands to the datapath.
    typedef struct packed {
        logic in_ready;
        logic load;
        logic mul;
        logic step;
        logic finish;
    } ctrl_t;

    // Datapath flags back to the sequencer.
    typedef struct packed {
        logic big;
        logic outside;
    } status_t;

endpackage

@@ rtl/core/mbe_if.sv @@
interface mbe_point_if;
    logic                            valid;
    logic                            ready;
    logic signed [mbe_pkg::C_W-1:0]  point_re;
    logic signed [mbe_pkg::C_W-1:0]  point_im;

    modport source (output valid, output point_re, output point_im, input ready);
    modport sink (input valid, input point_re, input point_im, output ready);
endinterface

interface mbe_result_if #(
    parameter int COUNT_WIDTH = 10
);
    logic                            valid;
    logic                            ready;
    logic                            escaped;
    logic [COUNT_WIDTH-1:0]          iterations;
    logic signed [mbe_pkg::Z_W-1:0]  final_re;
    logic signed [mbe_pkg::Z_W-1:0]  final_im;

    modport source (
        output valid, output escaped, output iterations,
        output final_re, output final_im, input ready
    );
    modport sink (
        input valid, input escaped, input iterations,
        input final_re, input final_im, output ready
    );
endinterface

interface mbe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mbe_pkg::LIMIT_W-1:0]      iteration_limit;

    modport source (output valid, output iteration_limit, input ready);
    modport sink (input valid, input iteration_limit, output ready);
endinterface

@@ rtl/core/mandelbrot_escape_time.sv @@
// Channel  Role    Payload
// point    sink    point_re, point_im (signed, 28 fraction bits)
// result   source  escaped, iterations, final_re, final_im
// cfg      sink    iteration_limit (always ready)
//
// Each iteration of a point takes one multiply step (ST_MUL) and one combine-and-test step
// (ST_CHK); a part of z above two ends the point in the multiply step, before squaring.
// The point channel is ready only while no point is in work; a finished result sits
// in the output register, so a new point is taken while the result waits.
// A result that finishes while the output register is still full waits until it drains.
// Reset is asynchronous, active low; iteration_limit resets to 110.
module mandelbrot_escape_time #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mbe_point_if.sink            point,
    mbe_result_if.source         result,
    mbe_cfg_if.sink              cfg
);

    localparam int ZW = mbe_pkg::Z_W;
    localparam int CW = mbe_pkg::C_W;
    localparam int LW = mbe_pkg::LIMIT_W;

    mbe_pkg::ctrl_t          ctrl;
    mbe_pkg::status_t        status;
    logic [LW-1:0]           count;
    logic                    escaped;
    logic                    out_free;
    logic [LW-1:0]           limit_reg;
    logic signed [ZW-1:0]    re_reg;
    logic signed [ZW-1:0]    im_reg;
    logic signed [CW-1:0]    c_re_reg;
    logic signed [CW-1:0]    c_im_reg;
    logic signed [ZW-1:0]    next_re;
    logic signed [ZW-1:0]    next_im;
    logic                    out_valid_reg;
    logic                    escaped_reg;
    logic [COUNT_WIDTH-1:0]  iterations_reg;
    logic signed [ZW-1:0]    final_re_reg;
    logic signed [ZW-1:0]    final_im_reg;

    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= mbe_pkg::LIMIT_RESET;
        else if (cfg.valid)
            limit_reg <= cfg.iteration_limit;
    end

    mbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (point.valid),
        .out_free (out_free),
        .limit    (limit_reg),
        .status   (status),
        .ctrl     (ctrl),
        .count    (count),
        .escaped  (escaped)
    );

    mbe_cplx_unit u_unit (
        .clk     (clk),
        .mul_en  (ctrl.mul),
        .z_re    (re_reg),
        .z_im    (im_reg),
        .c_re    (c_re_reg),
        .c_im    (c_im_reg),
        .next_re (next_re),
        .next_im (next_im),
        .status  (status)
    );

    assign point.ready = ctrl.in_ready;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            re_reg   <= '0;
            im_reg   <= '0;
            c_re_reg <= point.point_re;
            c_im_reg <= point.point_im;
        end
        else if (ctrl.step)
        begin
            re_reg <= next_re;
            im_reg <= next_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.finish)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            escaped_reg    <= escaped;
            iterations_reg <= COUNT_WIDTH'(count);
            final_re_reg   <= re_reg;
            final_im_reg   <= im_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.escaped    = escaped_reg;
    assign result.iterations = iterations_reg;
    assign result.final_re   = final_re_reg;
    assign result.final_im   = final_im_reg;

endmodule

@@ rtl/core/mbe_cplx_unit.sv @@
module mbe_cplx_unit (
    input  logic                           clk,
    input  logic                           mul_en,
    input  logic signed [mbe_pkg::Z_W-1:0] z_re,
    input  logic signed [mbe_pkg::Z_W-1:0] z_im,
    input  logic signed [mbe_pkg::C_W-1:0] c_re,
    input  logic signed [mbe_pkg::C_W-1:0] c_im,
    output logic signed [mbe_pkg::Z_W-1:0] next_re,
    output logic signed [mbe_pkg::Z_W-1:0] next_im,
    output mbe_pkg::status_t               status
);

    localparam int ZW = mbe_pkg::Z_W;
    localparam int CW = mbe_pkg::C_W;
    localparam int OW = mbe_pkg::OP_W;
    localparam int PW = mbe_pkg::PROD_W;
    localparam int SW = mbe_pkg::SUM_W;
    localparam int FB = mbe_pkg::FRACTION_BITS;

    logic [ZW-1:0]        mag_re;
    logic [ZW-1:0]        mag_im;
    logic signed [OW-1:0] op_re;
    logic signed [OW-1:0] op_im;
    logic signed [PW-1:0] sq_re_reg;
    logic signed [PW-1:0] sq_im_reg;
    logic signed [PW-1:0] cross_reg;
    logic [SW-1:0]        mag_sq;
    logic signed [PW-1:0] diff;
    logic signed [PW-1:0] diff_sh;
    logic signed [PW-1:0] cross_sh;
    logic [ZW-1:0]        c_re_ext;
    logic [ZW-1:0]        c_im_ext;

    // Range check first: a part above 2 in magnitude escapes without squaring.
    assign mag_re = z_re[ZW-1] ? (~z_re + ZW'(1)) : z_re;
    assign mag_im = z_im[ZW-1] ? (~z_im + ZW'(1)) : z_im;
    assign status.big = (mag_re > mbe_pkg::TWO_Z) || (mag_im > mbe_pkg::TWO_Z);

    assign op_re = z_re[OW-1:0];
    assign op_im = z_im[OW-1:0];

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            sq_re_reg <= op_re * op_re;
            sq_im_reg <= op_im * op_im;
            cross_reg <= op_re * op_im;
        end
    end

    assign mag_sq = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign status.outside = mag_sq > mbe_pkg::FOUR_SQ;

    // Floor to the z format; the factor two of the cross term is one less shift.
    assign diff     = sq_re_reg - sq_im_reg;
    assign diff_sh  = diff >>> FB;
    assign cross_sh = cross_reg >>> (FB - 1);

    assign c_re_ext = {{(ZW - CW){c_re[CW-1]}}, c_re};
    assign c_im_ext = {{(ZW - CW){c_im[CW-1]}}, c_im};

    assign next_re = diff_sh[ZW-1:0] + c_re_ext;
    assign next_im = cross_sh[ZW-1:0] + c_im_ext;

endmodule

@@ rtl/core/mbe_ctrl.sv @@
module mbe_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             out_free,
    input  logic [mbe_pkg::LIMIT_W-1:0]      limit,
    input  mbe_pkg::status_t                 status,
    output mbe_pkg::ctrl_t                   ctrl,
    output logic [mbe_pkg::LIMIT_W-1:0]      count,
    output logic                             escaped
);

    mbe_pkg::state_t               state_reg;
    mbe_pkg::state_t               state_next;
    logic [mbe_pkg::LIMIT_W-1:0]   count_reg;
    logic [mbe_pkg::LIMIT_W-1:0]   count_next;
    logic                          below_limit;

    assign below_limit = count_reg < limit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbe_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = mbe_pkg::ST_MUL;
            end
            mbe_pkg::ST_MUL:
            begin
                if (status.big)
                    state_next = mbe_pkg::ST_DONE;
                else
                    state_next = mbe_pkg::ST_CHK;
            end
            mbe_pkg::ST_CHK:
            begin
                if (status.outside || !below_limit)
                    state_next = mbe_pkg::ST_DONE;
                else
                    state_next = mbe_pkg::ST_MUL;
            end
            mbe_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = mbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            mbe_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.load     = in_valid;
            end
            mbe_pkg::ST_MUL:
            begin
                ctrl.mul = !status.big;
            end
            mbe_pkg::ST_CHK:
            begin
                ctrl.step = !status.outside && below_limit;
            end
            mbe_pkg::ST_DONE:
            begin
                ctrl.finish = out_free;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load)
            count_next = '0;
        else if (ctrl.step)
            count_next = count_reg + mbe_pkg::LIMIT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbe_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign count   = count_reg;
    assign escaped = below_limit;

`ifndef SYNTHESIS
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (state_reg == mbe_pkg::ST_MUL) && (count_reg == '0))
        else $error("load did not start a fresh iteration");

    a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |=> (count_reg == $past(count_reg) + mbe_pkg::LIMIT_W'(1))
                      && (state_reg == mbe_pkg::ST_MUL))
        else $error("iteration step did not advance the count");

    a_finish_idles: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> state_reg == mbe_pkg::ST_IDLE)
        else $error("finish did not return to idle");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.load, ctrl.mul, ctrl.step, ctrl.finish}))
        else $error("more than one sequencer command at once");
`endif

endmodule

@@ test/tb_top.sv @@
module tb_top;

    localparam int FRACTION_BITS  = mbe_pkg::FRACTION_BITS;
    localparam int C_W            = mbe_pkg::C_W;
    localparam int Z_W            = mbe_pkg::Z_W;
    localparam int LIMIT_W        = mbe_pkg::LIMIT_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = mbe_pkg::LIMIT_RESET;

    localparam int COUNT_W        = 10;
    localparam int ONE_FX         = 1 << FRACTION_BITS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_STRETCH   = 1000;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};
    localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};

    typedef struct packed {
        logic                  escaped;
        logic [COUNT_W-1:0]    iterations;
        logic signed [Z_W-1:0] final_re;
        logic signed [Z_W-1:0] final_im;
    } escape_outcome_t;

    logic clk;
    logic rst_n;

    mbe_point_if                               point_ch ();
    mbe_result_if #(.COUNT_WIDTH(COUNT_W))     result_ch ();
    mbe_cfg_if                                 cfg_ch ();

    mandelbrot_escape_time #(
        .COUNT_WIDTH(COUNT_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    escape_outcome_t    pending_outcomes[$];
    logic [LIMIT_W-1:0] limit_setting = LIMIT_RESET;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_cycles = 0;
    int                 failures = 0;
    int                 quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Iterates z <- z*z + c from zero. The squares are exact at twice the
    // fraction bits and are floored back before c is added.
    function automatic escape_outcome_t escape_time(
        input logic signed [C_W-1:0] c_re,
        input logic signed [C_W-1:0] c_im,
        input logic [LIMIT_W-1:0]    limit
    );
        longint          zr;
        longint          zi;
        longint          ar;
        longint          ai;
        longint          next_re;
        longint          two_fx;
        longint          four_sq;
        int unsigned     count;
        bit              stop;
        escape_outcome_t outcome;
        zr      = 0;
        zi      = 0;
        count   = 0;
        stop    = 1'b0;
        two_fx  = longint'(2) << FRACTION_BITS;
        four_sq = longint'(4) << (2 * FRACTION_BITS);
        while (!stop)
        begin
            ar = (zr < 0) ? -zr : zr;
            ai = (zi < 0) ? -zi : zi;
            // A part above two means escape; the squares are not formed then.
            if (ar > two_fx || ai > two_fx)
                stop = 1'b1;
            else if (ar * ar + ai * ai > four_sq)
                stop = 1'b1;
            else if (count >= limit)
                stop = 1'b1;
            else
            begin
                next_re = ((zr * zr - zi * zi) >>> FRACTION_BITS) + longint'(c_re);
                zi      = ((2 * zr * zi) >>> FRACTION_BITS) + longint'(c_im);
                zr      = next_re;
                count++;
            end
        end
        outcome.escaped    = (count < limit);
        outcome.iterations = COUNT_W'(count);
        outcome.final_re   = Z_W'(zr);
        outcome.final_im   = Z_W'(zi);
        return outcome;
    endfunction

    task automatic send_point(
        input logic signed [C_W-1:0] re,
        input logic signed [C_W-1:0] im
    );
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(negedge clk);
        end
        point_ch.valid    <= 1'b1;
        point_ch.point_re <= re;
        point_ch.point_im <= im;
        do
            @(posedge clk);
        while (!point_ch.ready);
        pending_outcomes.push_back(escape_time(re, im, limit_setting));
    endtask

    // Ends any offer on the point channel and waits for every result.
    task automatic wait_drained();
        @(negedge clk);
        point_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        wait_drained();
        @(negedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.iteration_limit <= limit;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        limit_setting = limit;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mixes raw 32-bit values, a box around the disk of radius two and a box
    // around the set itself, where points tend to run to the limit.
    task automatic pick_point(
        output logic signed [C_W-1:0] re,
        output logic signed [C_W-1:0] im
    );
        int unsigned mode;
        mode = $urandom_range(0, 99);
        if (mode < 30)
        begin
            re = $urandom;
            im = $urandom;
        end
        else if (mode < 75)
        begin
            re = int'($urandom_range(0, 5 * ONE_FX)) - 5 * ONE_FX / 2;
            im = int'($urandom_range(0, 5 * ONE_FX)) - 5 * ONE_FX / 2;
        end
        else
        begin
            re = int'($urandom_range(0, 5 * ONE_FX / 2)) - 2 * ONE_FX;
            im = int'($urandom_range(0, 5 * ONE_FX / 2)) - 5 * ONE_FX / 4;
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_point(0, 0);
        send_point(-2 * ONE_FX, 0);
        send_point(2 * ONE_FX, 0);
        send_point(2 * ONE_FX + 1, 0);
        send_point(0, 2 * ONE_FX);
        send_point(0, ONE_FX);
        send_point(ONE_FX / 4, 0);
        send_point(ONE_FX / 4 + 1, 0);
        send_point(-ONE_FX, 0);
        send_point(3 * ONE_FX / 2, 3 * ONE_FX / 2);
        send_point(-ONE_FX + 1, -1);
        send_point(C_MIN, C_MIN);
        send_point(C_MAX, C_MAX);
        send_point(C_MIN, C_MAX);
        send_point(C_MAX, C_MIN);
        wait_drained();
    endtask

    task automatic test_limit_edges();
        // With no iterations allowed the result is all zero.
        write_limit(0);
        send_point(0, 0);
        send_point(C_MAX, C_MIN);
        // Escapes found only after the last allowed iteration do not count.
        write_limit(1);
        send_point(3 * ONE_FX, 0);
        send_point(0, 0);
        write_limit(2);
        send_point(2 * ONE_FX, 0);
        write_limit(3);
        send_point(2 * ONE_FX, 0);
        write_limit({LIMIT_W{1'b1}});
        send_point(0, 0);
        send_point(-2 * ONE_FX, 0);
        send_point(0, ONE_FX);
        wait_drained();
    endtask

    task automatic random_phase(
        input int n,
        input int limit_lo,
        input int limit_hi,
        input int send_pct,
        input int recv_pct
    );
        logic signed [C_W-1:0] re;
        logic signed [C_W-1:0] im;
        write_limit(LIMIT_W'($urandom_range(limit_lo, limit_hi)));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n)
        begin
            pick_point(re, im);
            send_point(re, im);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        random_phase(300, 110, 110, 0, 0);
        random_phase(300, 1, 200, 61, 0);
        random_phase(300, 110, 110, 0, 61);
        random_phase(300, 1, 200, 8, 8);
        random_phase(100, 0, 0, 61, 61);
        random_phase(100, 1, 1, 61, 0);
        random_phase(60, 1023, 1023, 8, 8);
        random_phase(100, 2, 16, 0, 0);
    endtask

    // The receiver stops for a long stretch while points keep coming, so the
    // output register fills and the point channel has to stall.
    task automatic test_backpressure();
        logic signed [C_W-1:0] re;
        logic signed [C_W-1:0] im;
        write_limit(LIMIT_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = HOLD_STRETCH;
        repeat (12)
        begin
            pick_point(re, im);
            send_point(re, im);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        point_ch.valid         = 1'b0;
        point_ch.point_re      = '0;
        point_ch.point_im      = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.iteration_limit = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_limit_edges();
        test_random_traffic();
        test_backpressure();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        escape_outcome_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result transfer with no point outstanding");
                failures++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result_ch.escaped !== want.escaped)
                begin
                    $error("escaped: expected %0d, got %0d", want.escaped, result_ch.escaped);
                    failures++;
                end
                if (result_ch.iterations !== want.iterations)
                begin
                    $error("iterations: expected %0d, got %0d",
                           want.iterations, result_ch.iterations);
                    failures++;
                end
                if (result_ch.final_re !== want.final_re)
                begin
                    $error("final_re: expected %0d, got %0d", want.final_re, result_ch.final_re);
                    failures++;
                end
                if (result_ch.final_im !== want.final_im)
                begin
                    $error("final_im: expected %0d, got %0d", want.final_im, result_ch.final_im);
                    failures++;
                end
            end
        end
    end

    // Any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n
            || (point_ch.valid && point_ch.ready)
            || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

@@ files.f @@
rtl/core/mbe_pkg.sv
rtl/core/mbe_if.sv
rtl/core/mbe_cplx_unit.sv
rtl/core/mbe_ctrl.sv
rtl/core/mandelbrot_escape_time.sv
test/tb_top.sv
